FILE: rtl/base64_stream_encoder_macros.svh
// Assertion macros shared by the encoder modules.
`ifndef BASE64_STREAM_ENCODER_MACROS_SVH
`define BASE64_STREAM_ENCODER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define B64E_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define B64E_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/b64e_pkg.sv
// Types, constants and the character table of the Base64 encoder.
package b64e_pkg;

    localparam int unsigned C_CHARS = 4;
    localparam logic [6:0] C_PAD_CODE = 7'd61;
    localparam logic [6:0] C_CODE_PLUS = 7'd43;
    localparam logic [6:0] C_CODE_SLASH = 7'd47;
    localparam logic [6:0] C_OFS_UPPER = 7'd65;
    localparam logic [6:0] C_OFS_LOWER = 7'd71;
    localparam logic [6:0] C_SUB_DIGIT = 7'd4;

    typedef logic [1:0] t_phase;

    typedef struct packed {
        logic [C_CHARS-1:0][5:0] sextet;
        logic [C_CHARS-1:0]      is_pad;
        logic [1:0]              last_idx;
        logic                    fin;
    } t_cmd;

    function automatic logic [6:0] f_sextet_char(input logic [5:0] s);
        logic [6:0] c;
        priority if (s < 6'd26) begin
            c = C_OFS_UPPER + {1'b0, s};
        end else if (s < 6'd52) begin
            c = C_OFS_LOWER + {1'b0, s};
        end else if (s < 6'd62) begin
            c = {1'b0, s} - C_SUB_DIGIT;
        end else if (s == 6'd62) begin
            c = C_CODE_PLUS;
        end else begin
            c = C_CODE_SLASH;
        end
        return c;
    endfunction

endpackage

FILE: rtl/b64e_front.sv
// Front end: accepts bytes, tracks group position, builds character commands.
`include "base64_stream_encoder_macros.svh"

module b64e_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_tvalid,
    output logic          o_tready,
    input  logic [7:0]    i_data,
    input  logic          i_fin,
    input  logic          i_full,
    output logic          o_push,
    output b64e_pkg::t_cmd o_cmd
);

    b64e_pkg::t_phase r_phase;
    b64e_pkg::t_phase n_phase;
    logic [3:0]       r_left;
    logic [3:0]       n_left;
    b64e_pkg::t_cmd   w_cmd;

    assign o_tready = !i_full;
    assign o_push   = i_tvalid && !i_full;
    assign o_cmd    = w_cmd;

    always_comb begin
        w_cmd         = '0;
        n_phase       = r_phase;
        n_left        = r_left;
        unique case (r_phase)
            2'd1: begin
                w_cmd.sextet[0] = {r_left[1:0], i_data[7:4]};
                w_cmd.last_idx  = 2'd0;
                n_left          = i_data[3:0];
                n_phase         = 2'd2;
            end
            2'd2: begin
                w_cmd.sextet[0] = {r_left, i_data[7:6]};
                w_cmd.sextet[1] = i_data[5:0];
                w_cmd.last_idx  = 2'd1;
                n_left          = 4'd0;
                n_phase         = 2'd0;
            end
            default: begin
                w_cmd.sextet[0] = i_data[7:2];
                w_cmd.last_idx  = 2'd0;
                n_left          = {2'b00, i_data[1:0]};
                n_phase         = 2'd1;
            end
        endcase
        if (i_fin) begin
            w_cmd.fin = 1'b1;
            unique case (n_phase)
                2'd1: begin
                    w_cmd.sextet[1] = {n_left[1:0], 4'b0000};
                    w_cmd.is_pad[2] = 1'b1;
                    w_cmd.is_pad[3] = 1'b1;
                    w_cmd.last_idx  = 2'd3;
                end
                2'd2: begin
                    w_cmd.sextet[1] = {n_left, 2'b00};
                    w_cmd.is_pad[2] = 1'b1;
                    w_cmd.last_idx  = 2'd2;
                end
                default: begin
                    w_cmd.last_idx  = 2'd1;
                end
            endcase
            n_phase = 2'd0;
            n_left  = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_left  <= 4'd0;
        end else if (o_push) begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    `B64E_ASSERT_IMP(a_phase_range, i_clk, i_rst_n, 1'b1, r_phase != 2'd3, "phase out of range")
    `B64E_ASSERT_NXT(a_fin_restart, i_clk, i_rst_n, o_push && i_fin,
        r_phase == 2'd0 && r_left == 4'd0, "state not cleared after final byte")

endmodule

FILE: rtl/b64e_fifo.sv
// Short command queue between front and back ends.
`include "base64_stream_encoder_macros.svh"

module b64e_fifo #(
    parameter int unsigned P_DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64e_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output b64e_pkg::t_cmd o_cmd
);

    localparam int unsigned AW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CW = $clog2(P_DEPTH + 1);
    localparam logic [AW-1:0] C_LAST_PTR = AW'(P_DEPTH - 1);
    localparam logic [CW-1:0] C_DEPTH = CW'(P_DEPTH);

    b64e_pkg::t_cmd r_mem [P_DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    assign o_full  = (r_count == C_DEPTH);
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == C_LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == C_LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `B64E_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")
    `B64E_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")

endmodule

FILE: rtl/b64e_back.sv
// Back end: steps through each command and drives one character per transfer.
`include "base64_stream_encoder_macros.svh"

module b64e_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  b64e_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_tvalid,
    input  logic           i_tready,
    output logic [6:0]     o_char,
    output logic           o_last
);

    logic [1:0] r_idx;
    logic       r_ovalid;
    logic [6:0] r_char;
    logic       r_olast;
    logic       w_adv;
    logic       w_end;
    logic [6:0] w_char;

    assign w_adv  = i_valid && (!r_ovalid || i_tready);
    assign w_end  = (r_idx == i_cmd.last_idx);
    assign o_pop  = w_adv && w_end;
    assign w_char = i_cmd.is_pad[r_idx] ? b64e_pkg::C_PAD_CODE
                                        : b64e_pkg::f_sextet_char(i_cmd.sextet[r_idx]);

    assign o_tvalid = r_ovalid;
    assign o_char   = r_char;
    assign o_last   = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= 2'd0;
            r_ovalid <= 1'b0;
        end else if (w_adv) begin
            r_ovalid <= 1'b1;
            r_idx    <= w_end ? 2'd0 : r_idx + 2'd1;
        end else if (i_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_char  <= w_char;
            r_olast <= i_cmd.fin && w_end;
        end
    end

    `B64E_ASSERT_IMP(a_idx_bound, i_clk, i_rst_n, i_valid, r_idx <= i_cmd.last_idx,
        "character index past end of command")
    `B64E_ASSERT_NXT(a_idx_wrap, i_clk, i_rst_n, o_pop, r_idx == 2'd0,
        "index not rewound after command")

endmodule

FILE: rtl/base64_stream_encoder.sv
// Top level of the Base64 stream encoder with padding.
//
//  channel  dir  tdata                          tlast
//  s        in   [7:0] data byte                final byte of message
//  m        out  [6:0] char code, [7] zero      final character of message
//
// One character leaves per cycle while m is ready; a byte is taken per cycle while the
// queue has room. Sustained rate is set by the single-character output. A final byte
// emits 2 to 4 characters, padding included. i_rst_n low clears group state, queue
// and output valid. m stalls hold the output register; the queue of P_DEPTH
// commands keeps s flowing until it fills.
module base64_stream_encoder #(
    parameter int unsigned P_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [6:0] char_code, [7] zero
    output logic       o_m_tlast
);

    logic           w_push;
    logic           w_pop;
    logic           w_full;
    logic           w_valid;
    b64e_pkg::t_cmd w_cmd_in;
    b64e_pkg::t_cmd w_cmd_out;
    logic [6:0]     w_char;

    b64e_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (i_s_tvalid),
        .o_tready (o_s_tready),
        .i_data   (i_s_tdata),
        .i_fin    (i_s_tlast),
        .i_full   (w_full),
        .o_push   (w_push),
        .o_cmd    (w_cmd_in)
    );

    b64e_fifo #(
        .P_DEPTH (P_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_valid),
        .o_cmd   (w_cmd_out)
    );

    b64e_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid),
        .i_cmd    (w_cmd_out),
        .o_pop    (w_pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_char   (w_char),
        .o_last   (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, w_char};

endmodule

FILE: tb/tb_base64_stream_encoder.sv
// Self-checking testbench for the Base64 stream encoder: byte stream in, checked characters out.
module tb_base64_stream_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam b64e_pkg::t_phase PH_START = 2'd0;
    localparam b64e_pkg::t_phase PH_ONE = 2'd1;
    localparam b64e_pkg::t_phase PH_TWO = 2'd2;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam logic [64*8-1:0] B64_CHARS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } t_char;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'h00;   // [7:0] data_byte
    logic       i_s_tlast = 1'b0;
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;           // [6:0] char_code, [7] zero
    logic       o_m_tlast;

    t_char            char_q[$];
    b64e_pkg::t_phase enc_phase = PH_START;
    logic [3:0]       enc_left = 4'h0;
    bit               quiet = 1'b0;
    bit               running = 1'b0;
    int               hold_left = 0;
    int               stall_cycles = 0;
    int               mismatch_count = 0;
    int               chars_checked = 0;
    int               bytes_sent = 0;
    int               messages_sent = 0;

    base64_stream_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [6:0] sextet_ascii(input logic [5:0] s);
        int idx;
        idx = 8 * (63 - int'(s));
        return B64_CHARS[idx +: 7];
    endfunction

    function automatic bit take_gap();
        return !quiet && ($urandom_range(0, 99) < 4);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic fin);
        logic [6:0] codes [4];
        t_char      entry;
        int         n;
        if (enc_phase == PH_ONE) begin
            codes[0] = sextet_ascii({enc_left[1:0], b[7:4]});
            n = 1;
            enc_left = b[3:0];
            enc_phase = PH_TWO;
        end else if (enc_phase == PH_TWO) begin
            codes[0] = sextet_ascii({enc_left, b[7:6]});
            codes[1] = sextet_ascii(b[5:0]);
            n = 2;
            enc_left = 4'h0;
            enc_phase = PH_START;
        end else begin
            codes[0] = sextet_ascii(b[7:2]);
            n = 1;
            enc_left = {2'b00, b[1:0]};
            enc_phase = PH_ONE;
        end
        if (fin) begin
            if (enc_phase == PH_ONE) begin
                codes[1] = sextet_ascii({enc_left[1:0], 4'h0});
                codes[2] = b64e_pkg::C_PAD_CODE;
                codes[3] = b64e_pkg::C_PAD_CODE;
                n = 4;
            end else if (enc_phase == PH_TWO) begin
                codes[1] = sextet_ascii({enc_left, 2'b00});
                codes[2] = b64e_pkg::C_PAD_CODE;
                n = 3;
            end
            enc_phase = PH_START;
            enc_left = 4'h0;
        end
        for (int i = 0; i < n; i++) begin
            entry.code = codes[i];
            entry.last = fin && (i == n - 1);
            char_q = {char_q, entry};
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= b;
        i_s_tlast <= fin;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        encode_byte(b, fin);
        bytes_sent++;
        if (fin) messages_sent++;
        if (take_gap()) begin
            gap = $urandom_range(1, 4);
            i_s_tvalid <= 1'b0;
            i_s_tdata <= 8'($urandom);
            i_s_tlast <= 1'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (char_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_extremes();
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b1);
    endtask

    task automatic test_final_positions();
        send_byte(8'h80, 1'b1);
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b1);
    endtask

    task automatic test_random_messages(input int n_bytes);
        int target;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 9) < 8) send_message($urandom_range(1, 8));
            else send_message($urandom_range(9, 30));
        end
    endtask

    task automatic test_no_idle_stretch();
        quiet = 1'b1;
        test_random_messages(80);
        quiet = 1'b0;
    endtask

    task automatic test_output_hold_off();
        quiet = 1'b1;
        hold_left <= HOLD_OFF_CYCLES;
        send_message(24);
        quiet = 1'b0;
    endtask

    task automatic test_drain_pause();
        send_message(5);
        wait_drained();
        send_message(1);
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            i_m_tready <= quiet || ($urandom_range(0, 99) >= 10);
        end
    end

    always @(posedge i_clk) begin : char_monitor
        t_char want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (char_q.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h", o_m_tdata));
            end else begin
                want = char_q.pop_front();
                chars_checked++;
                if (o_m_tdata !== {1'b0, want.code}) begin
                    report_mismatch($sformatf("char 0x%02h, want 0x%02h",
                                              o_m_tdata, {1'b0, want.code}));
                end
                if (o_m_tlast !== want.last) begin
                    report_mismatch($sformatf("tlast %b, want %b", o_m_tlast, want.last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (running) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("base64_stream_encoder regression: fail");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        running = 1'b1;
        test_extremes();
        test_final_positions();
        test_output_hold_off();
        test_drain_pause();
        test_no_idle_stretch();
        test_random_messages(300);
        wait_drained();
        repeat (12) @(posedge i_clk);
        $display("encoded %0d bytes in %0d messages, %0d characters checked",
                 bytes_sent, messages_sent, chars_checked);
        $display("all group endings, output hold-off, drain pause and idle-free stretch run");
        if (mismatch_count == 0) begin
            $display("base64_stream_encoder regression: pass");
        end else begin
            $display("base64_stream_encoder regression: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_fifo.sv
rtl/b64e_back.sv
rtl/base64_stream_encoder.sv
tb/tb_base64_stream_encoder.sv
